FILE: hw/rtl/sorted_timer_queue_macros.svh
// Assertion macros used by the checker file.
`ifndef SORTED_TIMER_QUEUE_MACROS_SVH
`define SORTED_TIMER_QUEUE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define STQ_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Implication checked on the clock edge after the condition.
`define STQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

FILE: hw/rtl/stq_pkg.sv
// Package with the types and constants of the sorted timer queue.
package stq_pkg;
	localparam int MaxTimers = 8;
	localparam int SlotW = 3;
	localparam int CntW = 4;
	localparam int DueLimit = 8;
	localparam logic [47:0] TimeMax = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_DEL = 2'd1;
	localparam logic [1:0] OP_REFRESH = 2'd2;

	localparam logic [2:0] KIND_ADDED = 3'd0;
	localparam logic [2:0] KIND_FULL = 3'd1;
	localparam logic [2:0] KIND_DELETED = 3'd2;
	localparam logic [2:0] KIND_UNKNOWN = 3'd3;
	localparam logic [2:0] KIND_EXPIRED = 3'd4;
	localparam logic [2:0] KIND_WAIT = 3'd5;

	// One request as it sits in the queue between front and back.
	typedef struct packed {
		logic [1:0] opcode;
		logic [47:0] now_ms;
		logic [31:0] interval_ms;
		logic repeat_req;
		logic [2:0] timer_id;
		logic [15:0] session_tag;
	} req_t;
endpackage

FILE: hw/rtl/stq_front.sv
// Front part: accepts requests, drops unused codes, and queues the rest.
module stq_front import stq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input req_t in_req,
	output logic q_valid,
	input logic q_take,
	output req_t q_req
);
	req_t buf_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	logic push;

	assign in_stall = (cnt_q == 2'd2);
	// Opcode three causes no result, so it is dropped on entry.
	assign push = in_valid && !in_stall && (in_req.opcode != 2'd3);
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = buf_q[rd_q];

	// Two entry queue between front and back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_take) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_req;
	end
endmodule

FILE: hw/rtl/stq_back.sv
// Back part: runs add, delete and refresh on the ordered timer table.
module stq_back import stq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_take,
	input req_t q_req,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] kind,
	output logic [2:0] slot,
	output logic [15:0] echo_tag,
	output logic signed [32:0] next_wait_ms,
	output logic last
);
	typedef enum logic [2:0] {
		S_IDLE, S_EMIT, S_DUE, S_PLACE, S_WAIT
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [47:0] deadline_q [MaxTimers];
	logic [31:0] period_q [MaxTimers];
	logic [MaxTimers-1:0] used_q;
	logic [SlotW-1:0] order_q [MaxTimers];
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] ndue_q;
	logic [CntW-1:0] lim_q;
	logic [SlotW-1:0] cur_q;
	logic rearm_q;

	logic [2:0] kind_q, slot_r_q;
	logic [15:0] tag_q;
	logic signed [32:0] wait_q;
	logic last_q, ovalid_q;

	logic out_free;
	logic due_now;
	logic emit;
	logic [SlotW-1:0] free_s;
	logic free_ok;
	logic [48:0] sum_add, sum_per;
	logic [47:0] dl_add, dl_per;
	logic [CntW-1:0] ins_pos, del_pos;
	logic del_hit;
	logic [SlotW-1:0] head;
	logic [48:0] diff;

	assign out_free = !ovalid_q || !out_stall;
	assign q_take = (state_q == S_IDLE) && q_valid && out_free;
	assign head = order_q[0];

	// Lowest free slot.
	always_comb begin
		free_s = '0;
		free_ok = 1'b0;
		for (int i = MaxTimers - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_s = SlotW'(i);
				free_ok = 1'b1;
			end
		end
	end

	// Saturating deadlines for add and for re-arm.
	assign sum_add = {1'b0, q_req.now_ms} + {17'd0, q_req.interval_ms};
	assign dl_add = sum_add[48] ? TimeMax : sum_add[47:0];
	assign sum_per = {1'b0, req_q.now_ms} + {17'd0, period_q[cur_q]};
	assign dl_per = sum_per[48] ? TimeMax : sum_per[47:0];

	// Insert position: count of entries with deadline at or before the new one.
	always_comb begin
		logic [47:0] key;
		key = (state_q == S_IDLE) ? dl_add : dl_per;
		ins_pos = '0;
		for (int i = 0; i < MaxTimers; i++) begin
			if (CntW'(i) < count_q && deadline_q[order_q[i]] <= key)
				ins_pos = ins_pos + 1'b1;
		end
	end

	// Position of the deleted slot in the list.
	always_comb begin
		del_pos = '0;
		del_hit = 1'b0;
		for (int i = MaxTimers - 1; i >= 0; i--) begin
			if (CntW'(i) < count_q && order_q[i] == q_req.timer_id) begin
				del_pos = CntW'(i);
				del_hit = 1'b1;
			end
		end
	end

	assign diff = {1'b0, deadline_q[head]} - {1'b0, req_q.now_ms};

	// The head expires now if it is due and belongs to the entries present at the start.
	assign due_now = count_q != '0 && ndue_q < lim_q && ndue_q < CntW'(DueLimit) &&
		deadline_q[head] <= req_q.now_ms;

	// A result is loaded into the output register in this cycle.
	assign emit = out_free && (state_q == S_EMIT || state_q == S_WAIT ||
		(state_q == S_DUE && due_now));

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			count_q <= '0;
			ovalid_q <= 1'b0;
			ndue_q <= '0;
			rearm_q <= 1'b0;
		end else begin
			ovalid_q <= emit || (ovalid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (q_valid && out_free) begin
						req_q <= q_req;
						ndue_q <= '0;
						lim_q <= count_q;
						wait_q <= '0;
						last_q <= 1'b1;
						priority if (q_req.opcode == OP_ADD) begin
							tag_q <= q_req.session_tag;
							if (!free_ok || count_q >= CntW'(MaxTimers)) begin
								kind_q <= KIND_FULL;
								slot_r_q <= '0;
							end else begin
								kind_q <= KIND_ADDED;
								slot_r_q <= free_s;
								used_q[free_s] <= 1'b1;
								deadline_q[free_s] <= dl_add;
								period_q[free_s] <= q_req.repeat_req ?
									q_req.interval_ms : 32'd0;
								for (int i = MaxTimers - 1; i > 0; i--)
									if (CntW'(i) > ins_pos) order_q[i] <= order_q[i-1];
								order_q[ins_pos[SlotW-1:0]] <= free_s;
								count_q <= count_q + 1'b1;
							end
							state_q <= S_EMIT;
						end else if (q_req.opcode == OP_DEL) begin
							tag_q <= 16'd0;
							slot_r_q <= q_req.timer_id;
							if (!used_q[q_req.timer_id]) begin
								kind_q <= KIND_UNKNOWN;
							end else begin
								kind_q <= KIND_DELETED;
								used_q[q_req.timer_id] <= 1'b0;
								if (del_hit) begin
									for (int i = 0; i < MaxTimers - 1; i++)
										if (CntW'(i) >= del_pos) order_q[i] <= order_q[i+1];
									count_q <= count_q - 1'b1;
								end
							end
							state_q <= S_EMIT;
						end else begin
							tag_q <= 16'd0;
							state_q <= S_DUE;
						end
					end
				end
				S_EMIT: begin
					// Final result waits for a free output register.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DUE: begin
					// Pop one due head and report it once the output register is free.
					if (out_free) begin
						if (due_now) begin
							kind_q <= KIND_EXPIRED;
							slot_r_q <= head;
							last_q <= 1'b0;
							cur_q <= head;
							ndue_q <= ndue_q + 1'b1;
							for (int i = 0; i < MaxTimers - 1; i++)
								order_q[i] <= order_q[i+1];
							count_q <= count_q - 1'b1;
							rearm_q <= (period_q[head] != 32'd0);
							if (period_q[head] == 32'd0) used_q[head] <= 1'b0;
							state_q <= S_PLACE;
						end else begin
							state_q <= S_WAIT;
						end
					end
				end
				S_PLACE: begin
					// Re-armed timers go back in order; the scan stops after the starting entries.
					if (rearm_q) begin
						deadline_q[cur_q] <= dl_per;
						for (int i = MaxTimers - 1; i > 0; i--)
							if (CntW'(i) > ins_pos) order_q[i] <= order_q[i-1];
						order_q[ins_pos[SlotW-1:0]] <= cur_q;
						count_q <= count_q + 1'b1;
					end
					state_q <= S_DUE;
				end
				S_WAIT: begin
					if (out_free) begin
						kind_q <= KIND_WAIT;
						slot_r_q <= '0;
						last_q <= 1'b1;
						if (count_q == '0) wait_q <= -33'sd1;
						else if (diff[48]) wait_q <= '0;
						else if (diff[47:32] != '0) wait_q <= 33'sh0FFFF_FFFF;
						else wait_q <= {1'b0, diff[31:0]};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign kind = kind_q;
	assign slot = slot_r_q;
	assign echo_tag = tag_q;
	assign next_wait_ms = wait_q;
	assign last = last_q;
endmodule

FILE: hw/rtl/sorted_timer_queue.sv
// Top level of the sorted timer queue.
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  opcode now_ms interval_ms repeat_req timer_id session_tag
// output    out        out_valid/out_stall kind slot echo_tag next_wait_ms last
// Add and delete are taken in S_IDLE and pass through S_EMIT; the result is offered
// once the output register is free.
// A refresh is taken in S_IDLE; each expired timer is reported in S_DUE and then
// re-inserted in S_PLACE if it repeats, and a final scan in S_DUE leads to the wait result in S_WAIT.
// Reset clears the slot flags and the list count; no clearing pass is needed.
// A stalled output holds the back part while the front queue keeps taking items until its two entries are full.
module sorted_timer_queue import stq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] opcode,
	input logic [47:0] now_ms,
	input logic [31:0] interval_ms,
	input logic repeat_req,
	input logic [2:0] timer_id,
	input logic [15:0] session_tag,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] kind,
	output logic [2:0] slot,
	output logic [15:0] echo_tag,
	output logic signed [32:0] next_wait_ms,
	output logic last
);
	req_t in_req, q_req;
	logic q_valid, q_take;

	assign in_req = '{opcode: opcode, now_ms: now_ms, interval_ms: interval_ms,
		repeat_req: repeat_req, timer_id: timer_id, session_tag: session_tag};

	stq_front u_front (.clk, .arst_n, .in_valid, .in_stall, .in_req,
		.q_valid, .q_take, .q_req);

	stq_back u_back (.clk, .arst_n, .q_valid, .q_take, .q_req, .out_valid,
		.out_stall, .kind, .slot, .echo_tag, .next_wait_ms, .last);
endmodule

FILE: hw/rtl/stq_checker.sv
// Port checker for the sorted timer queue, bound to the top level.
`include "sorted_timer_queue_macros.svh"
module stq_checker import stq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] kind,
	input logic [15:0] echo_tag,
	input logic signed [32:0] next_wait_ms,
	input logic last
);
	`STQ_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(kind))
	`STQ_ASSERT_IMP(a_wait_last, clk, arst_n, out_valid && kind == KIND_WAIT, last)
	`STQ_ASSERT_IMP(a_exp_mid, clk, arst_n, out_valid && kind == KIND_EXPIRED, !last && echo_tag == 16'd0)
	`STQ_ASSERT_IMP(a_wait_zero, clk, arst_n, out_valid && kind != KIND_WAIT, next_wait_ms == 33'sd0)
endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.clk, .arst_n, .out_valid, .out_stall,
	.kind, .echo_tag, .next_wait_ms, .last);
